/* src/p2tse_pkg.sv */
// Shared widths and constants of the P2 triangle shape function evaluator.
`default_nettype none
package p2tse_pkg;
	// coordinate width (signed, fixed point)
	localparam int CW = 24;
	// coordinate difference width
	localparam int EW = CW + 1;
	// product of two differences
	localparam int PRW = 2 * EW;
	// doubled area width (difference of two products)
	localparam int AW = PRW + 1;
	// magnitude of a doubled area, always below 2^49
	localparam int DW = 50;
	// result word width
	localparam int QW = 32;
	// quotient bits resolved by the divider, one per stage
	localparam int DIV_STEPS = QW;
	// divider latency: entry stage, bit stages, sign stage
	localparam int DIV_LAT = DIV_STEPS + 2;
	// division lanes: three barycentrics, three d/dx, three d/dy
	localparam int LANES = 9;
	// multiplier operand width (holds 4L-1 down to -2^33-1)
	localparam int OW = QW + 3;
	// signed product width
	localparam int MW = 2 * OW;
	// products per result beat: value, two for d/dx, two for d/dy
	localparam int NPROD = 5;
	// results per triangle
	localparam int NUM_BASIS = 6;
	localparam logic [2:0] LAST_IDX = 3'd5;
	// saturation limits, as magnitudes and as signed values
	localparam logic [QW-1:0] LIM_POS = 32'h7fff_ffff;
	localparam logic [QW-1:0] LIM_NEG = 32'h8000_0000;
	localparam logic signed [QW-1:0] SAT_MAX = 32'sh7fff_ffff;
	localparam logic signed [QW-1:0] SAT_MIN = 32'sh8000_0000;
endpackage
`default_nettype wire

/* src/p2tse_div.sv */
// Pipelined restoring divider: saturated signed quotient of (num / den), one bit per stage.
`default_nettype none
module p2tse_div #(
	parameter int NW = 66
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [NW-1:0]                  num,
	input  logic [p2tse_pkg::DW-1:0]       den,
	input  logic                           neg,
	output logic signed [p2tse_pkg::QW-1:0] quo
);
	localparam int QW = p2tse_pkg::QW;
	localparam int DW = p2tse_pkg::DW;
	localparam int ST = p2tse_pkg::DIV_STEPS;

	logic [DW-1:0] rem_s [0:ST];
	logic [DW-1:0] den_s [0:ST];
	logic [QW-1:0] quo_s [0:ST];
	logic [QW-1:0] nlo_s [0:ST];
	logic          neg_s [0:ST];
	logic          ovf_s [0:ST];

	logic [DW:0]   trial [1:ST];
	logic          ge    [1:ST];
	logic [QW-1:0] lim;
	logic [QW-1:0] qmag;

	// trial subtract for each bit stage
	always_comb begin
		for (int k = 1; k <= ST; k++) begin
			trial[k] = {rem_s[k-1], nlo_s[k-1][QW-1]};
			ge[k]    = (trial[k] >= {1'b0, den_s[k-1]});
		end
	end

	// clamp to the signed range and apply the sign
	always_comb begin
		lim  = neg_s[ST] ? p2tse_pkg::LIM_NEG : p2tse_pkg::LIM_POS;
		qmag = (ovf_s[ST] || (quo_s[ST] > lim)) ? lim : quo_s[ST];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// entry: upper part becomes the first remainder, flag quotient overflow
			rem_s[0] <= DW'(num[NW-1:QW]);
			ovf_s[0] <= (DW'(num[NW-1:QW]) >= den);
			nlo_s[0] <= num[QW-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg;
			// one quotient bit per stage
			for (int k = 1; k <= ST; k++) begin
				rem_s[k] <= ge[k] ? DW'(trial[k] - {1'b0, den_s[k-1]}) : DW'(trial[k]);
				quo_s[k] <= {quo_s[k-1][QW-2:0], ge[k]};
				nlo_s[k] <= {nlo_s[k-1][QW-2:0], 1'b0};
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
			quo <= neg_s[ST] ? -$signed(qmag) : $signed(qmag);
		end
	end
endmodule
`default_nettype wire

/* src/p2_triangle_shape_eval.sv */
// Top level: P2 Lagrange shape function values and gradients on a triangle, fully pipelined.
//
// channel | dir | fields (lowest bit first)
// s_      | in  | tdata: v0_x v0_y v1_x v1_y v2_x v2_y point_x point_y (8 x 24 bit)
// m_      | out | tdata: basis_value grad_x grad_y (3 x 32 bit); tuser: basis_index degenerate;
//         |     | tlast: last
//
// Each triangle gives six output beats, one per cycle while m_tready allows, so the
// one-beat-per-cycle result port limits the sustained rate at which triangles are taken.
// From input beat to first result the path runs through 4 setup stages, 34 divider
// stages, the beat sequencer and 4 multiply stages. Reset clears only the valid bits,
// the busy flag and beat index. A stall on m_ holds the output register and the multiply
// stages; once the sequencer is full the divider pipeline holds as well and s_tready drops.
`default_nettype none
module p2_triangle_shape_eval #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,   // v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, point_x, point_y
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // basis_value, grad_x, grad_y
	output logic [3:0]   m_tuser,   // basis_index [2:0], degenerate [3]
	output logic         m_tlast
);
	localparam int CW = p2tse_pkg::CW;
	localparam int EW = p2tse_pkg::EW;
	localparam int PRW = p2tse_pkg::PRW;
	localparam int AW = p2tse_pkg::AW;
	localparam int DW = p2tse_pkg::DW;
	localparam int QW = p2tse_pkg::QW;
	localparam int OW = p2tse_pkg::OW;
	localparam int MW = p2tse_pkg::MW;
	localparam int NP = p2tse_pkg::NPROD;
	localparam int LN = p2tse_pkg::LANES;
	localparam int DL = p2tse_pkg::DIV_LAT;
	localparam int NW = DW + FRAC_BITS;
	localparam logic signed [OW-1:0] ONE = OW'(1) <<< FRAC_BITS;

	// ---------------- input unpack ----------------
	logic signed [CW-1:0] vx [3];
	logic signed [CW-1:0] vy [3];
	logic signed [CW-1:0] px, py;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			vx[j] = s_tdata[2*j*CW +: CW];
			vy[j] = s_tdata[(2*j+1)*CW +: CW];
		end
		px = s_tdata[6*CW +: CW];
		py = s_tdata[7*CW +: CW];
	end

	logic en_p, en_o, ser_free, issue, load;

	// ---------------- s1: coordinate differences ----------------
	logic                 v_s1;
	logic signed [EW-1:0] e1x_s1, e1y_s1, e2x_s1, e2y_s1;
	logic signed [EW-1:0] qx_s1 [3];
	logic signed [EW-1:0] qy_s1 [3];
	logic signed [EW-1:0] dxn_s1 [3];
	logic signed [EW-1:0] dyn_s1 [3];

	always_ff @(posedge clk) begin
		if (en_p) begin
			e1x_s1 <= EW'(vx[1]) - EW'(vx[0]);
			e1y_s1 <= EW'(vy[1]) - EW'(vy[0]);
			e2x_s1 <= EW'(vx[2]) - EW'(vx[0]);
			e2y_s1 <= EW'(vy[2]) - EW'(vy[0]);
			for (int j = 0; j < 3; j++) begin
				qx_s1[j]  <= EW'(vx[j]) - EW'(px);
				qy_s1[j]  <= EW'(vy[j]) - EW'(py);
				dxn_s1[j] <= EW'(vy[(j+1)%3]) - EW'(vy[(j+2)%3]);
				dyn_s1[j] <= EW'(vx[(j+2)%3]) - EW'(vx[(j+1)%3]);
			end
		end
	end

	// ---------------- s2: cross products ----------------
	logic                  v_s2;
	logic signed [PRW-1:0] pa_s2, pb_s2;
	logic signed [PRW-1:0] pq_s2 [3];
	logic signed [PRW-1:0] pr_s2 [3];
	logic signed [EW-1:0]  dxn_s2 [3];
	logic signed [EW-1:0]  dyn_s2 [3];

	always_ff @(posedge clk) begin
		if (en_p) begin
			pa_s2 <= e1x_s1 * e2y_s1;
			pb_s2 <= e1y_s1 * e2x_s1;
			for (int j = 0; j < 3; j++) begin
				pq_s2[j]  <= qx_s1[(j+1)%3] * qy_s1[(j+2)%3];
				pr_s2[j]  <= qy_s1[(j+1)%3] * qx_s1[(j+2)%3];
				dxn_s2[j] <= dxn_s1[j];
				dyn_s2[j] <= dyn_s1[j];
			end
		end
	end

	// ---------------- s3: doubled areas ----------------
	logic                 v_s3;
	logic signed [AW-1:0] area_s3;
	logic signed [AW-1:0] sub_s3 [3];
	logic signed [EW-1:0] dxn_s3 [3];
	logic signed [EW-1:0] dyn_s3 [3];

	always_ff @(posedge clk) begin
		if (en_p) begin
			area_s3 <= AW'(pa_s2) - AW'(pb_s2);
			for (int j = 0; j < 3; j++) begin
				sub_s3[j] <= AW'(pq_s2[j]) - AW'(pr_s2[j]);
				dxn_s3[j] <= dxn_s2[j];
				dyn_s3[j] <= dyn_s2[j];
			end
		end
	end

	// ---------------- s4: magnitudes, signs, scaled numerators ----------------
	logic                 v_s4, degen_s4;
	logic [NW-1:0]        num_s4 [LN];
	logic                 neg_s4 [LN];
	logic [DW-1:0]        den_s4;
	logic signed [AW-1:0] area_abs;
	logic signed [AW-1:0] sub_abs [3];
	logic signed [EW-1:0] dxn_abs [3];
	logic signed [EW-1:0] dyn_abs [3];

	always_comb begin
		area_abs = area_s3[AW-1] ? -area_s3 : area_s3;
		for (int j = 0; j < 3; j++) begin
			sub_abs[j] = sub_s3[j][AW-1] ? -sub_s3[j] : sub_s3[j];
			dxn_abs[j] = dxn_s3[j][EW-1] ? -dxn_s3[j] : dxn_s3[j];
			dyn_abs[j] = dyn_s3[j][EW-1] ? -dyn_s3[j] : dyn_s3[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en_p) begin
			degen_s4 <= (area_s3 == '0);
			den_s4   <= area_abs[DW-1:0];
			for (int j = 0; j < 3; j++) begin
				num_s4[j]   <= NW'(sub_abs[j][DW-1:0]) << FRAC_BITS;
				neg_s4[j]   <= sub_s3[j][AW-1] ^ area_s3[AW-1];
				num_s4[3+j] <= NW'(dxn_abs[j]) << (2 * FRAC_BITS);
				neg_s4[3+j] <= dxn_s3[j][EW-1] ^ area_s3[AW-1];
				num_s4[6+j] <= NW'(dyn_abs[j]) << (2 * FRAC_BITS);
				neg_s4[6+j] <= dyn_s3[j][EW-1] ^ area_s3[AW-1];
			end
		end
	end

	// ---------------- divider lanes ----------------
	logic signed [QW-1:0] quo [LN];

	for (genvar l = 0; l < LN; l++) begin : g_div
		p2tse_div #(.NW(NW)) u_div (
			.clk (clk),
			.en  (en_p),
			.num (num_s4[l]),
			.den (den_s4),
			.neg (neg_s4[l]),
			.quo (quo[l])
		);
	end

	// carry degenerate flag alongside the dividers
	logic dg_q [DL];
	always_ff @(posedge clk) begin
		if (en_p) begin
			dg_q[0] <= degen_s4;
			for (int k = 1; k < DL; k++) dg_q[k] <= dg_q[k-1];
		end
	end

	// valid bits of the setup stages and divider lanes
	logic [DL-1:0] vd_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			vd_q <= '0;
		end else if (en_p) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			vd_q <= {vd_q[DL-2:0], v_s4};
		end
	end

	// ---------------- beat sequencer ----------------
	logic                 busy_q, degen_q;
	logic [2:0]           idx_q;
	logic signed [QW-1:0] lam_q [3];
	logic signed [QW-1:0] gdx_q [3];
	logic signed [QW-1:0] gdy_q [3];

	assign issue    = busy_q && en_o;
	assign ser_free = !busy_q || (issue && (idx_q == p2tse_pkg::LAST_IDX));
	assign en_p     = !vd_q[DL-1] || ser_free;
	assign load     = vd_q[DL-1] && ser_free;
	assign s_tready = en_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (issue) begin
			busy_q <= (idx_q != p2tse_pkg::LAST_IDX);
			idx_q  <= idx_q + 3'd1;
		end
	end

	// take one triangle's quotients
	always_ff @(posedge clk) begin
		if (load) begin
			degen_q <= dg_q[DL-1];
			for (int j = 0; j < 3; j++) begin
				lam_q[j] <= quo[j];
				gdx_q[j] <= quo[3+j];
				gdy_q[j] <= quo[6+j];
			end
		end
	end

	// ---------------- s5: operand select per basis function ----------------
	logic                 edge_sel;
	logic [1:0]           ia, ib;
	logic signed [OW-1:0] la, lb;
	logic signed [OW-1:0] opa [NP];
	logic signed [OW-1:0] opb [NP];

	always_comb begin
		case (idx_q)
			3'd0: begin edge_sel = 1'b0; ia = 2'd0; ib = 2'd0; end
			3'd1: begin edge_sel = 1'b0; ia = 2'd1; ib = 2'd1; end
			3'd2: begin edge_sel = 1'b0; ia = 2'd2; ib = 2'd2; end
			3'd3: begin edge_sel = 1'b1; ia = 2'd1; ib = 2'd2; end
			3'd4: begin edge_sel = 1'b1; ia = 2'd2; ib = 2'd0; end
			3'd5: begin edge_sel = 1'b1; ia = 2'd0; ib = 2'd1; end
			default: begin edge_sel = 1'b0; ia = 2'd0; ib = 2'd0; end
		endcase
		la = OW'(lam_q[ia]);
		lb = OW'(lam_q[ib]);
		if (edge_sel) begin
			opa[0] = la <<< 2;  opb[0] = lb;
			opa[1] = la <<< 2;  opb[1] = OW'(gdx_q[ib]);
			opa[2] = lb <<< 2;  opb[2] = OW'(gdx_q[ia]);
			opa[3] = la <<< 2;  opb[3] = OW'(gdy_q[ib]);
			opa[4] = lb <<< 2;  opb[4] = OW'(gdy_q[ia]);
		end else begin
			opa[0] = la;               opb[0] = (la <<< 1) - ONE;
			opa[1] = (la <<< 2) - ONE; opb[1] = OW'(gdx_q[ia]);
			opa[2] = '0;               opb[2] = '0;
			opa[3] = (la <<< 2) - ONE; opb[3] = OW'(gdy_q[ia]);
			opa[4] = '0;               opb[4] = '0;
		end
	end

	logic                 v_s5, v_s6, v_s7, v_s8;
	logic signed [OW-1:0] opa_s5 [NP];
	logic signed [OW-1:0] opb_s5 [NP];
	logic [2:0]           idx_s5, idx_s6, idx_s7, idx_s8;
	logic                 dg_s5, dg_s6, dg_s7, dg_s8;

	always_ff @(posedge clk) begin
		if (en_o) begin
			for (int j = 0; j < NP; j++) begin
				opa_s5[j] <= opa[j];
				opb_s5[j] <= opb[j];
			end
			idx_s5 <= idx_q;
			dg_s5  <= degen_q;
		end
	end

	// ---------------- s6: products ----------------
	logic signed [MW-1:0] prod_s6 [NP];

	always_ff @(posedge clk) begin
		if (en_o) begin
			for (int j = 0; j < NP; j++) prod_s6[j] <= opa_s5[j] * opb_s5[j];
			idx_s6 <= idx_s5;
			dg_s6  <= dg_s5;
		end
	end

	// ---------------- s7: scale, truncate toward zero, saturate ----------------
	logic signed [MW-1:0] pabs [NP];
	logic [MW-1:0]        psh  [NP];
	logic [QW-1:0]        plim [NP];
	logic [QW-1:0]        pmag [NP];
	logic signed [QW-1:0] pv_s7 [NP];

	always_comb begin
		for (int j = 0; j < NP; j++) begin
			pabs[j] = prod_s6[j][MW-1] ? -prod_s6[j] : prod_s6[j];
			psh[j]  = MW'(pabs[j]) >> FRAC_BITS;
			plim[j] = prod_s6[j][MW-1] ? p2tse_pkg::LIM_NEG : p2tse_pkg::LIM_POS;
			pmag[j] = (psh[j] > MW'(plim[j])) ? plim[j] : psh[j][QW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			for (int j = 0; j < NP; j++)
				pv_s7[j] <= prod_s6[j][MW-1] ? -$signed(pmag[j]) : $signed(pmag[j]);
			idx_s7 <= idx_s6;
			dg_s7  <= dg_s6;
		end
	end

	// ---------------- s8: gradient sums, output register ----------------
	logic signed [QW:0]   sum_x, sum_y;
	logic signed [QW-1:0] gx_sat, gy_sat;
	logic signed [QW-1:0] val_s8, gx_s8, gy_s8;

	always_comb begin
		sum_x = (QW+1)'(pv_s7[1]) + (QW+1)'(pv_s7[2]);
		sum_y = (QW+1)'(pv_s7[3]) + (QW+1)'(pv_s7[4]);
		if (sum_x > (QW+1)'(p2tse_pkg::SAT_MAX))      gx_sat = p2tse_pkg::SAT_MAX;
		else if (sum_x < (QW+1)'(p2tse_pkg::SAT_MIN)) gx_sat = p2tse_pkg::SAT_MIN;
		else                                          gx_sat = sum_x[QW-1:0];
		if (sum_y > (QW+1)'(p2tse_pkg::SAT_MAX))      gy_sat = p2tse_pkg::SAT_MAX;
		else if (sum_y < (QW+1)'(p2tse_pkg::SAT_MIN)) gy_sat = p2tse_pkg::SAT_MIN;
		else                                          gy_sat = sum_y[QW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			// zero the value and both gradients for a flat triangle
			val_s8 <= dg_s7 ? '0 : pv_s7[0];
			gx_s8  <= dg_s7 ? '0 : gx_sat;
			gy_s8  <= dg_s7 ? '0 : gy_sat;
			idx_s8 <= idx_s7;
			dg_s8  <= dg_s7;
		end
	end

	// valid bits of the multiply stages
	assign en_o = !v_s8 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en_o) begin
			v_s5 <= issue;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// ---------------- output beat ----------------
	assign m_tvalid = v_s8;
	assign m_tdata  = {gy_s8, gx_s8, val_s8};
	assign m_tuser  = {dg_s8, idx_s8};
	assign m_tlast  = (idx_s8 == p2tse_pkg::LAST_IDX);
endmodule
`default_nettype wire
